// File: rtl/rmad_pkg.sv
// shared types and constants for the relative mean absolute deviation unit
package rmad_pkg;

  // accumulator and divider dividend width (covers sum and deviation sum)
  localparam int DIV_W  = 48;
  // divisor width: sample count or magnitude of the mean
  localparam int DVSR_W = 32;
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MEAN_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT       = 2'd2;
  localparam logic [1:0] ST_DROPPED   = 2'd3;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } rmad_in_t;

  typedef struct packed {
    logic signed [31:0] dispersion;
    logic [1:0]         status;
  } rmad_out_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_MAD,
    DIV_RATIO
  } div_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_DEV,
    S_DRAIN,
    S_MAD_GO,
    S_MAD_WAIT,
    S_CHECK,
    S_RATIO_GO,
    S_RATIO_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd_clear;
    logic    rd_issue;
    logic    div_start;
    div_op_t div_op;
    logic    finish;
  } rmad_cmd_t;

  typedef struct packed {
    logic div_done;
    logic idx_last;
    logic pipe_busy;
    logic mean_zero;
  } rmad_stat_t;

endpackage

// File: rtl/rmad_ram.sv
// generic single-port-write, registered-read ram
module rmad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rmad_div.sv
// restoring unsigned divider, one quotient bit per cycle
module rmad_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rmad_pkg::DIV_W-1:0] dividend,
  input  logic [rmad_pkg::DVSR_W-1:0] divisor,
  output logic                       done,
  output logic [rmad_pkg::DIV_W-1:0] quotient
);

  logic                          busy;
  logic [rmad_pkg::STEP_W-1:0]   steps;
  logic [rmad_pkg::DVSR_W-1:0]   dvsr;
  logic [rmad_pkg::DVSR_W:0]     rem;
  logic [rmad_pkg::DVSR_W:0]     rem_sh;
  logic [rmad_pkg::DVSR_W:0]     rem_next;
  logic                          qbit;
  logic [rmad_pkg::DIV_W-1:0]    quo;

  always_comb begin
    rem_sh = {rem[rmad_pkg::DVSR_W-1:0], quo[rmad_pkg::DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dvsr});
    rem_next = qbit ? (rem_sh - {1'b0, dvsr}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= rmad_pkg::STEP_W'(rmad_pkg::DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == rmad_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[rmad_pkg::DIV_W-2:0], qbit};
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/rmad_ctrl.sv
// sequencing state machine for load, mean, deviation pass and divisions
module rmad_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 last,
  input  rmad_pkg::rmad_stat_t stat,
  output logic                 busy,
  output rmad_pkg::rmad_cmd_t  cmd
);

  rmad_pkg::state_t state;
  rmad_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmad_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rmad_pkg::S_IDLE: begin
        if (start && last) state_next = rmad_pkg::S_MEAN_GO;
      end
      rmad_pkg::S_MEAN_GO:   state_next = rmad_pkg::S_MEAN_WAIT;
      rmad_pkg::S_MEAN_WAIT: begin
        if (stat.div_done) state_next = rmad_pkg::S_DEV;
      end
      rmad_pkg::S_DEV: begin
        if (stat.idx_last) state_next = rmad_pkg::S_DRAIN;
      end
      rmad_pkg::S_DRAIN: begin
        if (!stat.pipe_busy) state_next = rmad_pkg::S_MAD_GO;
      end
      rmad_pkg::S_MAD_GO:   state_next = rmad_pkg::S_MAD_WAIT;
      rmad_pkg::S_MAD_WAIT: begin
        if (stat.div_done) state_next = rmad_pkg::S_CHECK;
      end
      rmad_pkg::S_CHECK: begin
        state_next = stat.mean_zero ? rmad_pkg::S_DONE : rmad_pkg::S_RATIO_GO;
      end
      rmad_pkg::S_RATIO_GO:   state_next = rmad_pkg::S_RATIO_WAIT;
      rmad_pkg::S_RATIO_WAIT: begin
        if (stat.div_done) state_next = rmad_pkg::S_DONE;
      end
      rmad_pkg::S_DONE: state_next = rmad_pkg::S_IDLE;
      default:          state_next = rmad_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.div_op = rmad_pkg::DIV_MEAN;
    busy      = 1'b1;
    unique case (state) inside
      rmad_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      rmad_pkg::S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = rmad_pkg::DIV_MEAN;
        cmd.rd_clear  = 1'b1;
      end
      rmad_pkg::S_DEV: cmd.rd_issue = 1'b1;
      rmad_pkg::S_MAD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = rmad_pkg::DIV_MAD;
      end
      rmad_pkg::S_RATIO_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = rmad_pkg::DIV_RATIO;
      end
      rmad_pkg::S_DONE: cmd.finish = 1'b1;
      rmad_pkg::S_MEAN_WAIT, rmad_pkg::S_DRAIN, rmad_pkg::S_MAD_WAIT,
      rmad_pkg::S_CHECK, rmad_pkg::S_RATIO_WAIT: begin
        cmd.rd_issue = 1'b0;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: rtl/rmad_datapath.sv
// sample store, accumulators, deviation pipeline, shared divider, result regs
module rmad_datapath #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rmad_pkg::rmad_in_t   request,
  input  rmad_pkg::rmad_cmd_t  cmd,
  output rmad_pkg::rmad_stat_t stat,
  output rmad_pkg::rmad_out_t  result,
  output logic                 done
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [CNT_W-1:0]              count;
  logic signed [rmad_pkg::DIV_W-1:0] sum;
  logic                          dropped;
  logic                          full;

  logic [CNT_W-1:0]              rd_idx;
  logic                          rd_valid;
  logic                          abs_valid;
  logic [31:0]                   rdata;
  logic signed [32:0]            diff;
  logic signed [32:0]            diff_neg;
  logic [31:0]                   dev_abs;
  logic [rmad_pkg::DIV_W-1:0]    devsum;

  logic signed [31:0]            mean;
  logic [31:0]                   mean_mag;
  logic [31:0]                   mad;
  logic [rmad_pkg::DIV_W-1:0]    q_mag;
  logic [rmad_pkg::DIV_W-1:0]    sum_neg;
  logic [rmad_pkg::DIV_W-1:0]    sum_mag;

  rmad_pkg::div_op_t             op;
  logic [rmad_pkg::DIV_W-1:0]    div_dividend;
  logic [rmad_pkg::DVSR_W-1:0]   div_divisor;
  logic                          div_done;
  logic [rmad_pkg::DIV_W-1:0]    div_quo;
  logic [31:0]                   quo_neg;

  logic signed [31:0]            disp_next;
  logic [1:0]                    status_next;
  logic                          sat;

  assign full = (count == CNT_W'(MAX_SAMPLES));

  // set accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else if (cmd.finish) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + 1'b1;
        sum   <= sum + rmad_pkg::DIV_W'(request.sample);
      end
    end
  end

  rmad_ram #(
    .WIDTH (32),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load && !full),
    .waddr (count[AW-1:0]),
    .wdata (request.sample),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // deviation pass: read, absolute difference, accumulate
  always_comb begin
    diff     = {rdata[31], rdata} - {mean[31], mean};
    diff_neg = -diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      abs_valid <= 1'b0;
    end else begin
      rd_valid  <= cmd.rd_issue;
      abs_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_clear) begin
      rd_idx <= '0;
      devsum <= '0;
    end else begin
      if (cmd.rd_issue) rd_idx <= rd_idx + 1'b1;
      if (abs_valid) devsum <= devsum + rmad_pkg::DIV_W'(dev_abs);
    end
    if (rd_valid) dev_abs <= diff[32] ? diff_neg[31:0] : diff[31:0];
  end

  // divider operand selection
  always_comb begin
    sum_neg  = -sum;
    sum_mag  = sum[rmad_pkg::DIV_W-1] ? sum_neg : sum;
    mean_mag = mean[31] ? (32'd0 - mean) : mean;
    div_dividend = sum_mag;
    div_divisor  = rmad_pkg::DVSR_W'(count);
    case (cmd.div_op)
      rmad_pkg::DIV_MEAN: begin
        div_dividend = sum_mag;
        div_divisor  = rmad_pkg::DVSR_W'(count);
      end
      rmad_pkg::DIV_MAD: begin
        div_dividend = devsum;
        div_divisor  = rmad_pkg::DVSR_W'(count);
      end
      rmad_pkg::DIV_RATIO: begin
        div_dividend = {mad, 16'd0};
        div_divisor  = mean_mag;
      end
      default: begin
        div_dividend = sum_mag;
        div_divisor  = rmad_pkg::DVSR_W'(count);
      end
    endcase
  end

  rmad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo_neg = 32'd0 - div_quo[31:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) op <= cmd.div_op;
    if (div_done) begin
      case (op)
        rmad_pkg::DIV_MEAN:
          mean <= sum[rmad_pkg::DIV_W-1] ? quo_neg : div_quo[31:0];
        rmad_pkg::DIV_MAD:   mad   <= div_quo[31:0];
        rmad_pkg::DIV_RATIO: q_mag <= div_quo;
        default:             q_mag <= div_quo;
      endcase
    end
  end

  // final sign, saturation and status
  always_comb begin
    if (mean[31]) begin
      sat       = (q_mag > rmad_pkg::DIV_W'(33'h0_8000_0000));
      disp_next = sat ? 32'sh8000_0000 : (32'd0 - q_mag[31:0]);
    end else begin
      sat       = (q_mag > rmad_pkg::DIV_W'(32'h7fff_ffff));
      disp_next = sat ? 32'sh7fff_ffff : q_mag[31:0];
    end
    if (dropped) status_next = rmad_pkg::ST_DROPPED;
    else if (sat) status_next = rmad_pkg::ST_SAT;
    else status_next = rmad_pkg::ST_OK;
    if (stat.mean_zero) begin
      disp_next   = '0;
      status_next = rmad_pkg::ST_MEAN_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.dispersion <= disp_next;
      result.status     <= status_next;
    end
  end

  always_comb begin
    stat.div_done  = div_done;
    stat.idx_last  = (rd_idx == count - 1'b1);
    stat.pipe_busy = rd_valid || abs_valid;
    stat.mean_zero = (mean == 32'sd0);
  end

endmodule

// File: rtl/relative_mean_abs_deviation_unit.sv
// top level of the relative mean absolute deviation unit
//
// request channel: a sample (signed q16.16) and a last mark are taken at a
//   rising edge where start is high and busy is low
// samples of a set load at one per cycle; busy stays low during loading
// a set holds at most MAX_SAMPLES stored samples; extra ones are dropped
//   and flagged in the status
// once the last request is taken, busy goes high and the unit works alone:
//   one division for the mean, a pass over the n stored samples through the
//   registered-read store, one division for the mean deviation and, unless
//   the mean is zero, one for the ratio
// the shared bit-serial divider (one quotient bit per cycle, 48 bits) and
//   the single read port of the sample store set the length of this work
// result channel: done is high for a single cycle as dispersion and status
//   appear on result, which holds until the next set ends; the receiver
//   cannot stall it, and a new set may start on the cycle done is shown
// reset (rst, synchronous) empties the set: count, sum and drop flag clear,
//   no result pending; store contents are left as they are
module relative_mean_abs_deviation_unit #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rmad_pkg::rmad_in_t  request,
  output logic                busy,
  output logic                done,
  output rmad_pkg::rmad_out_t result
);

  // command and status between sequencer and datapath
  rmad_pkg::rmad_cmd_t  cmd;
  rmad_pkg::rmad_stat_t stat;

  rmad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (request.last),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  rmad_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule

// File: rtl/rmad_checker.sv
// port-level checks for the relative mean absolute deviation unit
module rmad_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input rmad_pkg::rmad_in_t  request,
  input logic                busy,
  input logic                done,
  input rmad_pkg::rmad_out_t result
);

  // a result is a single-cycle strobe, never back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // a result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding busy cycle");

  // the last request of a set starts the computation
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.last) |=> busy)
    else $error("busy not raised after last request");

  // other requests keep the unit open for loading
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !request.last) |=> !busy)
    else $error("busy raised during sample loading");

  // zero mean reports zero dispersion
  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == rmad_pkg::ST_MEAN_ZERO) |-> (result.dispersion == 32'sd0))
    else $error("nonzero dispersion with zero mean status");

endmodule

bind relative_mean_abs_deviation_unit rmad_checker u_rmad_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .request (request),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
